### sv/audio_sample_ring_fifo_top_defines.svh
`ifndef AUDIO_SAMPLE_RING_FIFO_TOP_DEFINES_SVH
`define AUDIO_SAMPLE_RING_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define ASRF_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define ASRF_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/asrf_pkg.sv
package asrf_pkg;

	// Field widths
	localparam int SAMPLE_W   = 16;
	localparam int CMD_W      = 3;
	localparam int READ_W     = 7;
	localparam int CH_W       = 4;
	localparam int CAP_W      = 13;
	localparam int GAIN_W     = 15;
	localparam int FILL_W     = 13;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// Limits
	localparam int MAX_CHANNELS = 8;
	localparam int MAX_READ     = 64;
	localparam int DEPTH_DEF    = 4096;
	localparam int CH_IDX_W     = $clog2(MAX_CHANNELS);
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = $clog2(QDEPTH);

	// Gain arithmetic: unsigned Q1.14
	localparam int GAIN_FRAC = 14;
	localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
	localparam int SCL_W     = PROD_W + 1 - GAIN_FRAC;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 2'd2;

	// Register reset values
	localparam logic [CH_W-1:0]   RST_CHANNEL_COUNT = 4'd2;
	localparam logic [CAP_W-1:0]  RST_CAPACITY      = 13'd4096;
	localparam logic [GAIN_W-1:0] RST_GAIN          = 15'd16384;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STOP    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DROP    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_STOPPED = 2'd2;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_READ,
		OP_FLUSH,
		OP_STOP,
		OP_RESTART,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                                     op;
		logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0]   smp;
		logic [READ_W-1:0]                       n;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0]   channel_count;
		logic [CAP_W-1:0]  capacity;
		logic [GAIN_W-1:0] gain;
	} cfg_t;

	// Round half up, divide by unity gain, saturate to the sample range
	function automatic logic [SAMPLE_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0] t;
		logic [SCL_W-1:0]       q;
		logic [SCL_W-SAMPLE_W:0] top;
		t = {p[PROD_W-1], p} + (PROD_W+1)'(1 << (GAIN_FRAC - 1));
		q = t[PROD_W:GAIN_FRAC];
		top = q[SCL_W-1:SAMPLE_W-1];
		if (top == '0 || top == '1) begin
			scale_sat = q[SAMPLE_W-1:0];
		end else if (q[SCL_W-1]) begin
			scale_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			scale_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	endfunction

endpackage

### sv/asrf_if.sv
interface asrf_req_if;
	logic                                valid;
	logic                                ready;
	logic [asrf_pkg::CMD_W-1:0]          command;
	logic signed [asrf_pkg::SAMPLE_W-1:0] sample_0;
	logic signed [asrf_pkg::SAMPLE_W-1:0] sample_1;
	logic signed [asrf_pkg::SAMPLE_W-1:0] sample_2;
	logic signed [asrf_pkg::SAMPLE_W-1:0] sample_3;
	logic signed [asrf_pkg::SAMPLE_W-1:0] sample_4;
	logic signed [asrf_pkg::SAMPLE_W-1:0] sample_5;
	logic signed [asrf_pkg::SAMPLE_W-1:0] sample_6;
	logic signed [asrf_pkg::SAMPLE_W-1:0] sample_7;
	logic [asrf_pkg::READ_W-1:0]         read_count;

	modport source(output valid, command, sample_0, sample_1, sample_2, sample_3,
		sample_4, sample_5, sample_6, sample_7, read_count, input ready);
	modport sink(input valid, command, sample_0, sample_1, sample_2, sample_3,
		sample_4, sample_5, sample_6, sample_7, read_count, output ready);
endinterface

interface asrf_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [asrf_pkg::SAMPLE_W-1:0] sample_out;
	logic                                 last;
	logic [asrf_pkg::STATUS_W-1:0]        status;
	logic [asrf_pkg::FILL_W-1:0]          fill_level;

	modport source(output valid, sample_out, last, status, fill_level, input ready);
	modport sink(input valid, sample_out, last, status, fill_level, output ready);
endinterface

### sv/asrf_front.sv
module asrf_front (
	input  logic                clk,
	input  logic                arst_n,
	asrf_req_if.sink            req,
	output logic                q_valid,
	input  logic                q_ready,
	output asrf_pkg::item_t     q_item
);

	asrf_pkg::item_t                    entry_q [asrf_pkg::QDEPTH];
	asrf_pkg::item_t                    cls;
	logic [asrf_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [asrf_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [asrf_pkg::QPTR_W:0]          cnt_q;
	logic                               push;
	logic                               pop;

	// Decode the command and clamp the read length
	always_comb begin
		case (req.command)
			asrf_pkg::CMD_WRITE:   cls.op = asrf_pkg::OP_WRITE;
			asrf_pkg::CMD_READ:    cls.op = asrf_pkg::OP_READ;
			asrf_pkg::CMD_FLUSH:   cls.op = asrf_pkg::OP_FLUSH;
			asrf_pkg::CMD_STOP:    cls.op = asrf_pkg::OP_STOP;
			asrf_pkg::CMD_RESTART: cls.op = asrf_pkg::OP_RESTART;
			default:               cls.op = asrf_pkg::OP_NOP;
		endcase
		cls.smp[0] = req.sample_0;
		cls.smp[1] = req.sample_1;
		cls.smp[2] = req.sample_2;
		cls.smp[3] = req.sample_3;
		cls.smp[4] = req.sample_4;
		cls.smp[5] = req.sample_5;
		cls.smp[6] = req.sample_6;
		cls.smp[7] = req.sample_7;
		if (req.read_count == '0) begin
			cls.n = asrf_pkg::READ_W'(1);
		end else if (req.read_count > asrf_pkg::READ_W'(asrf_pkg::MAX_READ)) begin
			cls.n = asrf_pkg::READ_W'(asrf_pkg::MAX_READ);
		end else begin
			cls.n = req.read_count;
		end
	end

	assign req.ready = (cnt_q != (asrf_pkg::QPTR_W+1)'(asrf_pkg::QDEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_valid && q_ready;
	assign q_item    = entry_q[rd_ptr_q];

	// Advance queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Hold classified beats
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= cls;
	end

endmodule

### sv/asrf_back.sv
module asrf_back #(
	parameter int DEPTH = asrf_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  asrf_pkg::cfg_t      cfg,
	input  logic                q_valid,
	output logic                q_ready,
	input  asrf_pkg::item_t     q_item,
	asrf_rsp_if.source          rsp
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = IDX_W + 1;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_WRITE    = 6'b000010,
		S_RD_FETCH = 6'b000100,
		S_RD_MUL   = 6'b001000,
		S_RD_SCALE = 6'b010000,
		S_EMIT     = 6'b100000
	} state_t;

	state_t                                         state_q;
	logic [IDX_W-1:0]                               widx_q;
	logic [IDX_W-1:0]                               ridx_q;
	logic [CNT_W-1:0]                               count_q;
	logic                                           stopped_q;
	logic [asrf_pkg::CH_IDX_W-1:0]                  ch_idx_q;
	logic [asrf_pkg::READ_W-1:0]                    rem_q;
	logic [asrf_pkg::SAMPLE_W-1:0]                  res_smp_q;
	logic                                           res_last_q;
	logic [asrf_pkg::STATUS_W-1:0]                  res_status_q;
	logic                                           out_valid_q;
	logic [asrf_pkg::SAMPLE_W-1:0]                  out_smp_q;
	logic                                           out_last_q;
	logic [asrf_pkg::STATUS_W-1:0]                  out_status_q;
	logic [asrf_pkg::FILL_W-1:0]                    out_fill_q;
	logic [asrf_pkg::MAX_CHANNELS-1:0][asrf_pkg::SAMPLE_W-1:0] cur_smp_q;
	logic [asrf_pkg::SAMPLE_W-1:0]                  mem [DEPTH];
	logic signed [asrf_pkg::SAMPLE_W-1:0]           rdata_q;
	logic signed [asrf_pkg::PROD_W-1:0]             prod_q;

	logic [CNT_W-1:0]                               cap_eff;
	logic [asrf_pkg::CH_W-1:0]                      ch_eff;
	logic                                           no_fit;
	logic                                           ch_done;
	logic                                           have_data;
	logic                                           take;
	logic                                           out_free;
	logic                                           mem_we;
	logic                                           mem_re;
	logic [asrf_pkg::STATUS_W-1:0]                  run_status;

	function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
		input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = {1'b0, idx} + CNT_W'(1);
		if (n >= cap || n >= CNT_W'(DEPTH)) begin
			adv = '0;
		end else begin
			adv = n[IDX_W-1:0];
		end
	endfunction

	// Clamp the registers to their working ranges
	always_comb begin
		if (cfg.capacity == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(cfg.capacity) > 32'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(cfg.capacity);
		end
		if (cfg.channel_count == '0) begin
			ch_eff = asrf_pkg::CH_W'(1);
		end else if (cfg.channel_count > asrf_pkg::CH_W'(asrf_pkg::MAX_CHANNELS)) begin
			ch_eff = asrf_pkg::CH_W'(asrf_pkg::MAX_CHANNELS);
		end else begin
			ch_eff = cfg.channel_count;
		end
	end

	assign no_fit     = ({1'b0, count_q} + (CNT_W+1)'(ch_eff)) > {1'b0, cap_eff};
	assign ch_done    = ({1'b0, ch_idx_q} + asrf_pkg::CH_W'(1)) == ch_eff;
	assign have_data  = !stopped_q && (count_q != '0);
	assign q_ready    = (state_q == S_IDLE);
	assign take       = q_valid && q_ready;
	assign out_free   = !out_valid_q || rsp.ready;
	assign mem_we     = (state_q == S_WRITE);
	assign mem_re     = (state_q == S_RD_FETCH) && have_data;
	assign run_status = stopped_q ? asrf_pkg::ST_STOPPED : asrf_pkg::ST_OK;

	assign rsp.valid      = out_valid_q;
	assign rsp.sample_out = out_smp_q;
	assign rsp.last       = out_last_q;
	assign rsp.status     = out_status_q;
	assign rsp.fill_level = out_fill_q;

	// Sequence commands, ring pointers and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			widx_q       <= '0;
			ridx_q       <= '0;
			count_q      <= '0;
			stopped_q    <= 1'b0;
			ch_idx_q     <= '0;
			rem_q        <= '0;
			res_smp_q    <= '0;
			res_last_q   <= 1'b0;
			res_status_q <= asrf_pkg::ST_OK;
			out_valid_q  <= 1'b0;
			out_smp_q    <= '0;
			out_last_q   <= 1'b0;
			out_status_q <= asrf_pkg::ST_OK;
			out_fill_q   <= '0;
		end else begin
			if (rsp.ready && state_q != S_EMIT) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						res_smp_q  <= '0;
						res_last_q <= 1'b1;
						case (q_item.op)
							asrf_pkg::OP_WRITE: begin
								if (stopped_q) begin
									res_status_q <= asrf_pkg::ST_STOPPED;
									state_q      <= S_EMIT;
								end else if (no_fit) begin
									res_status_q <= asrf_pkg::ST_DROP;
									state_q      <= S_EMIT;
								end else begin
									ch_idx_q <= '0;
									state_q  <= S_WRITE;
								end
							end
							asrf_pkg::OP_READ: begin
								rem_q   <= q_item.n;
								state_q <= S_RD_FETCH;
							end
							asrf_pkg::OP_FLUSH: begin
								widx_q       <= '0;
								ridx_q       <= '0;
								count_q      <= '0;
								res_status_q <= run_status;
								state_q      <= S_EMIT;
							end
							asrf_pkg::OP_STOP: begin
								stopped_q    <= 1'b1;
								res_status_q <= asrf_pkg::ST_STOPPED;
								state_q      <= S_EMIT;
							end
							asrf_pkg::OP_RESTART: begin
								widx_q       <= '0;
								ridx_q       <= '0;
								count_q      <= '0;
								stopped_q    <= 1'b0;
								res_status_q <= asrf_pkg::ST_OK;
								state_q      <= S_EMIT;
							end
							default: begin
								res_status_q <= run_status;
								state_q      <= S_EMIT;
							end
						endcase
					end
				end
				S_WRITE: begin
					widx_q   <= adv(widx_q, cap_eff);
					count_q  <= count_q + CNT_W'(1);
					ch_idx_q <= ch_idx_q + 1'b1;
					if (ch_done) begin
						res_status_q <= asrf_pkg::ST_OK;
						state_q      <= S_EMIT;
					end
				end
				S_RD_FETCH: begin
					rem_q        <= rem_q - 1'b1;
					res_last_q   <= (rem_q == asrf_pkg::READ_W'(1));
					res_status_q <= run_status;
					if (have_data) begin
						ridx_q  <= adv(ridx_q, cap_eff);
						count_q <= count_q - CNT_W'(1);
						state_q <= S_RD_MUL;
					end else begin
						res_smp_q <= '0;
						state_q   <= S_EMIT;
					end
				end
				S_RD_MUL: begin
					state_q <= S_RD_SCALE;
				end
				S_RD_SCALE: begin
					res_smp_q <= asrf_pkg::scale_sat(prod_q);
					state_q   <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_smp_q    <= res_smp_q;
						out_last_q   <= res_last_q;
						out_status_q <= res_status_q;
						out_fill_q   <= asrf_pkg::FILL_W'(count_q);
						state_q      <= res_last_q ? S_IDLE : S_RD_FETCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the frame being written
	always_ff @(posedge clk) begin
		if (take) cur_smp_q <= q_item.smp;
	end

	// Single-port sample memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[widx_q] <= cur_smp_q[ch_idx_q];
		end else if (mem_re) begin
			rdata_q <= mem[ridx_q];
		end
	end

	// Apply the gain
	always_ff @(posedge clk) begin
		if (state_q == S_RD_MUL) begin
			prod_q <= rdata_q * $signed({1'b0, cfg.gain});
		end
	end

endmodule

### sv/audio_sample_ring_fifo_top.sv
// A frame write runs S_WRITE per channel, then S_EMIT; other controls go to S_EMIT;
// a read runs fetch, multiply, scale, emit per stored sample; fetch, emit per silent one.
// Throughput is set by the single-port sample memory (one sample a cycle) and the
// fetch, multiply, scale sequence of the read path; a 2-entry queue takes beats meanwhile.
// Reset (arst_n low) clears pointers, fill count, stopped flag and registers to defaults;
// sample memory contents are not cleared.
`include "audio_sample_ring_fifo_top_defines.svh"

module audio_sample_ring_fifo_top #(
	parameter int DEPTH = asrf_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	asrf_req_if.sink                          req,
	asrf_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [asrf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [asrf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	asrf_pkg::cfg_t  cfg_q;
	asrf_pkg::item_t q_item;
	logic            q_valid;
	logic            q_ready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= asrf_pkg::RST_CHANNEL_COUNT;
			cfg_q.capacity      <= asrf_pkg::RST_CAPACITY;
			cfg_q.gain          <= asrf_pkg::RST_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				asrf_pkg::CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[asrf_pkg::CH_W-1:0];
				asrf_pkg::CFG_CAPACITY:      cfg_q.capacity <= cfg_data[asrf_pkg::CAP_W-1:0];
				asrf_pkg::CFG_GAIN:          cfg_q.gain <= cfg_data[asrf_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	asrf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	asrf_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.rsp     (rsp)
	);

	// Stopped results carry silence only
	`ASRF_ASSERT_IMP(a_stopped_silent, rsp.valid && rsp.status == asrf_pkg::ST_STOPPED, rsp.sample_out == '0, "stopped result carries a nonzero sample")
	// A dropped frame is always a single closing beat with silence
	`ASRF_ASSERT_IMP(a_drop_single, rsp.valid && rsp.status == asrf_pkg::ST_DROP, rsp.last && rsp.sample_out == '0, "drop status on a non-final or nonzero beat")
	// Fill level never runs past the memory depth
	`ASRF_ASSERT_IMP(a_fill_bound, rsp.valid, 32'(rsp.fill_level) <= 32'(DEPTH), "fill level above memory depth")
	// A beat that is not last is followed by more beats of the same read, never a drop
	`ASRF_ASSERT_NXT(a_read_cont, rsp.valid && rsp.ready && !rsp.last, !(rsp.valid && rsp.status == asrf_pkg::ST_DROP), "drop status inside a read burst")

endmodule

### verif/audio_sample_ring_fifo_top_tb.sv
module audio_sample_ring_fifo_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import asrf_pkg::*;

	localparam logic [CMD_W-1:0] CMD_TOP = {CMD_W{1'b1}};
	localparam longint SMP_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
	localparam longint SMP_MIN = -SMP_MAX - 1;
	localparam longint HALF_LSB = 64'sd1 <<< (GAIN_FRAC - 1);
	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 56;
	localparam int TAIL_CYCLES = 64;
	localparam int RUN_LIMIT_NS = 20_000_000;

	typedef struct packed {
		logic [CMD_W-1:0]                      command;
		logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] smp;
		logic [READ_W-1:0]                     read_count;
		logic                                  drain_first;
	} ring_cmd_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] smp;
		logic                last;
		logic [STATUS_W-1:0] status;
		logic [FILL_W-1:0]   fill;
	} ring_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	asrf_req_if cmd_bus ();
	asrf_rsp_if beat_bus ();

	audio_sample_ring_fifo_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (cmd_bus),
		.rsp       (beat_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Pending commands, the one on the bus, and predicted output beats
	ring_cmd_t  cmd_q [$];
	ring_cmd_t  cmd_held;
	ring_beat_t ring_out_q [$];
	int         src_idle_pct;
	int         snk_idle_pct;
	int         err_count;

	// Mirror of the ring state and its registers
	logic [SAMPLE_W-1:0] ring_mem [DEPTH_DEF];
	int                  ring_wr;
	int                  ring_rd;
	int                  ring_fill;
	logic                ring_stopped;
	logic [CH_W-1:0]     ring_ch;
	logic [CAP_W-1:0]    ring_cap;
	logic [GAIN_W-1:0]   ring_gain;

	// Phase settings for the random part: channels, capacity, gain, idling
	int ph_ch   [N_PHASES] = '{2, 8, 1, 3, 0, 12, 5, 8};
	int ph_cap  [N_PHASES] = '{4096, 27, 5, 64, 1, 8191, 100, 40};
	int ph_gain [N_PHASES] = '{16384, 20000, 8192, 32767, 0, 1, 12345, 24576};
	int ph_idle [N_PHASES] = '{30, 30, 30, 30, 30, 30, 0, 30};

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic flag_mismatch(input string msg);
		err_count++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	function automatic int ring_cap_eff();
		if (ring_cap == '0) return 1;
		if (ring_cap > DEPTH_DEF) return DEPTH_DEF;
		return int'(ring_cap);
	endfunction

	function automatic int ring_ch_eff();
		if (ring_ch == '0) return 1;
		if (ring_ch > MAX_CHANNELS) return MAX_CHANNELS;
		return int'(ring_ch);
	endfunction

	// Advance an index, wrapping at the capacity in force
	function automatic int ring_next(input int idx);
		int nxt;
		nxt = idx + 1;
		if (nxt >= ring_cap_eff() || nxt >= DEPTH_DEF) nxt = 0;
		return nxt;
	endfunction

	// Scale by Q1.14 gain, round half up (floor of sum), saturate
	function automatic logic [SAMPLE_W-1:0] gain_sat(input logic [SAMPLE_W-1:0] s);
		longint prod;
		prod = longint'($signed(s)) * longint'(ring_gain) + HALF_LSB;
		prod = prod >>> GAIN_FRAC;
		if (prod > SMP_MAX) prod = SMP_MAX;
		if (prod < SMP_MIN) prod = SMP_MIN;
		return prod[SAMPLE_W-1:0];
	endfunction

	function automatic void expect_beat(input logic [SAMPLE_W-1:0] smp, input logic last,
			input logic [STATUS_W-1:0] status);
		ring_beat_t b;
		b.smp = smp;
		b.last = last;
		b.status = status;
		b.fill = FILL_W'(ring_fill);
		ring_out_q.push_back(b);
	endfunction

	// Apply one accepted command to the mirror and queue its beats
	function automatic void predict_ring_step(input ring_cmd_t c);
		int                  ch;
		int                  n;
		int                  k;
		logic [STATUS_W-1:0] st;
		logic [SAMPLE_W-1:0] smp;
		case (c.command)
			CMD_WRITE: begin
				ch = ring_ch_eff();
				if (ring_stopped) begin
					st = ST_STOPPED;
				end else if (ring_fill + ch > ring_cap_eff()) begin
					st = ST_DROP;
				end else begin
					for (k = 0; k < ch; k++) begin
						ring_mem[ring_wr] = c.smp[k];
						ring_wr = ring_next(ring_wr);
						ring_fill++;
					end
					st = ST_OK;
				end
				expect_beat('0, 1'b1, st);
			end
			CMD_READ: begin
				n = int'(c.read_count);
				if (n == 0) n = 1;
				if (n > MAX_READ) n = MAX_READ;
				for (k = 0; k < n; k++) begin
					smp = '0;
					if (!ring_stopped && ring_fill > 0) begin
						smp = gain_sat(ring_mem[ring_rd]);
						ring_rd = ring_next(ring_rd);
						ring_fill--;
					end
					expect_beat(smp, k == n - 1, ring_stopped ? ST_STOPPED : ST_OK);
				end
			end
			CMD_FLUSH, CMD_RESTART: begin
				ring_wr = 0;
				ring_rd = 0;
				ring_fill = 0;
				if (c.command == CMD_RESTART) ring_stopped = 1'b0;
				expect_beat('0, 1'b1, ring_stopped ? ST_STOPPED : ST_OK);
			end
			CMD_STOP: begin
				ring_stopped = 1'b1;
				expect_beat('0, 1'b1, ST_STOPPED);
			end
			default: begin
				expect_beat('0, 1'b1, ring_stopped ? ST_STOPPED : ST_OK);
			end
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
			1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic ring_cmd_t mk_item(input logic [CMD_W-1:0] cmd, input int rc);
		ring_cmd_t it;
		int        k;
		it.command = cmd;
		for (k = 0; k < MAX_CHANNELS; k++) it.smp[k] = pick_sample();
		it.read_count = READ_W'(rc);
		it.drain_first = 1'b0;
		return it;
	endfunction

	// Mostly frames and reads, with occasional control and unused codes
	function automatic ring_cmd_t rand_item();
		ring_cmd_t it;
		int        roll;
		int        rc;
		roll = $urandom_range(99);
		rc = $urandom_range(1, 16);
		if ($urandom_range(19) == 0) rc = $urandom_range(0, (1 << READ_W) - 1);
		if (roll < 46) begin
			it = mk_item(CMD_WRITE, rc);
		end else if (roll < 84) begin
			it = mk_item(CMD_READ, rc);
		end else if (roll < 88) begin
			it = mk_item(CMD_FLUSH, rc);
		end else if (roll < 91) begin
			it = mk_item(CMD_STOP, rc);
		end else if (roll < 97) begin
			it = mk_item(CMD_RESTART, rc);
		end else begin
			it = mk_item(CMD_W'($urandom_range(int'(CMD_RESTART) + 1, int'(CMD_TOP))), rc);
		end
		it.drain_first = ($urandom_range(49) == 0);
		return it;
	endfunction

	// Write all three registers back to back, then update the mirror
	task automatic set_regs(input logic [CH_W-1:0] ch, input logic [CAP_W-1:0] cap,
			input logic [GAIN_W-1:0] gain);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CHANNEL_COUNT;
		cfg_data <= CFG_DATA_W'(ch);
		@(posedge clk);
		cfg_index <= CFG_CAPACITY;
		cfg_data <= CFG_DATA_W'(cap);
		@(posedge clk);
		cfg_index <= CFG_GAIN;
		cfg_data <= CFG_DATA_W'(gain);
		@(posedge clk);
		cfg_we <= 1'b0;
		ring_ch = ch;
		ring_cap = cap;
		ring_gain = gain;
	endtask

	// Return at a rising edge once nothing is queued, on the bus or predicted
	task automatic wait_ring_idle();
		do @(posedge clk);
		while (cmd_q.size() != 0 || cmd_bus.valid || ring_out_q.size() != 0);
	endtask

	// Command driver: predict on each accepted beat, then load the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				predict_ring_step(cmd_held);
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (cmd_q.size() != 0 && (!cmd_q[0].drain_first || ring_out_q.size() == 0)
						&& $urandom_range(99) >= src_idle_pct) begin
					cmd_held = cmd_q.pop_front();
					cmd_bus.command <= cmd_held.command;
					cmd_bus.sample_0 <= cmd_held.smp[0];
					cmd_bus.sample_1 <= cmd_held.smp[1];
					cmd_bus.sample_2 <= cmd_held.smp[2];
					cmd_bus.sample_3 <= cmd_held.smp[3];
					cmd_bus.sample_4 <= cmd_held.smp[4];
					cmd_bus.sample_5 <= cmd_held.smp[5];
					cmd_bus.sample_6 <= cmd_held.smp[6];
					cmd_bus.sample_7 <= cmd_held.smp[7];
					cmd_bus.read_count <= cmd_held.read_count;
					cmd_bus.valid <= 1'b1;
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compare each accepted beat with the oldest prediction
	always @(posedge clk) begin
		ring_beat_t want;
		if (!arst_n) begin
			beat_bus.ready <= 1'b0;
		end else begin
			if (beat_bus.valid && beat_bus.ready) begin
				if (ring_out_q.size() == 0) begin
					flag_mismatch($sformatf("beat with nothing predicted, sample_out %0h",
						beat_bus.sample_out));
				end else begin
					want = ring_out_q.pop_front();
					if (beat_bus.sample_out !== want.smp)
						flag_mismatch($sformatf("sample_out %0h, want %0h",
							beat_bus.sample_out, want.smp));
					if (beat_bus.last !== want.last)
						flag_mismatch($sformatf("last %0b, want %0b", beat_bus.last, want.last));
					if (beat_bus.status !== want.status)
						flag_mismatch($sformatf("status %0d, want %0d",
							beat_bus.status, want.status));
					if (beat_bus.fill_level !== want.fill)
						flag_mismatch($sformatf("fill_level %0d, want %0d",
							beat_bus.fill_level, want.fill));
				end
			end
			beat_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		ring_cmd_t it;
		int        p;

		// Hold every input at a known value through reset
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_CHANNEL_COUNT;
		cfg_data = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.command = CMD_WRITE;
		cmd_bus.sample_0 = '0;
		cmd_bus.sample_1 = '0;
		cmd_bus.sample_2 = '0;
		cmd_bus.sample_3 = '0;
		cmd_bus.sample_4 = '0;
		cmd_bus.sample_5 = '0;
		cmd_bus.sample_6 = '0;
		cmd_bus.sample_7 = '0;
		cmd_bus.read_count = '0;
		beat_bus.ready = 1'b0;
		src_idle_pct = 30;
		snk_idle_pct = 30;
		err_count = 0;
		ring_wr = 0;
		ring_rd = 0;
		ring_fill = 0;
		ring_stopped = 1'b0;
		ring_ch = RST_CHANNEL_COUNT;
		ring_cap = RST_CAPACITY;
		ring_gain = RST_GAIN;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset registers: empty read, extreme frames, unused codes, stop handling
		cmd_q.push_back(mk_item(CMD_READ, 0));
		it = mk_item(CMD_WRITE, 0);
		it.smp = {MAX_CHANNELS{{1'b0, {(SAMPLE_W-1){1'b1}}}}};
		cmd_q.push_back(it);
		it = mk_item(CMD_WRITE, 0);
		it.smp = {MAX_CHANNELS{{1'b1, {(SAMPLE_W-1){1'b0}}}}};
		cmd_q.push_back(it);
		it = mk_item(CMD_WRITE, 0);
		it.smp[0] = '0;
		it.smp[1] = '1;
		cmd_q.push_back(it);
		it = mk_item(CMD_READ, 7);
		it.drain_first = 1'b1;
		cmd_q.push_back(it);
		cmd_q.push_back(mk_item(CMD_W'(CMD_RESTART + 1), 0));
		cmd_q.push_back(mk_item(CMD_TOP, 0));
		cmd_q.push_back(mk_item(CMD_WRITE, 0));
		cmd_q.push_back(mk_item(CMD_STOP, 0));
		cmd_q.push_back(mk_item(CMD_WRITE, 0));
		cmd_q.push_back(mk_item(CMD_READ, 3));
		cmd_q.push_back(mk_item(CMD_FLUSH, 0));
		cmd_q.push_back(mk_item(CMD_RESTART, 0));
		cmd_q.push_back(mk_item(CMD_READ, (1 << READ_W) - 1));

		// Eight channels, tiny ring, top gain: full ring, drop, saturation
		wait_ring_idle();
		set_regs(CH_W'(8), CAP_W'(16), {GAIN_W{1'b1}});
		cmd_q.push_back(mk_item(CMD_FLUSH, 0));
		it = mk_item(CMD_WRITE, 0);
		it.smp = {MAX_CHANNELS{{1'b0, {(SAMPLE_W-1){1'b1}}}}};
		cmd_q.push_back(it);
		it = mk_item(CMD_WRITE, 0);
		it.smp = {MAX_CHANNELS{{1'b1, {(SAMPLE_W-1){1'b0}}}}};
		cmd_q.push_back(it);
		cmd_q.push_back(mk_item(CMD_WRITE, 0));
		cmd_q.push_back(mk_item(CMD_READ, 13));

		// Shrink capacity without flush: read index past the end wraps, writes blocked
		wait_ring_idle();
		set_regs(CH_W'(15), CAP_W'(8), CFG_DATA_W'(RST_GAIN));
		cmd_q.push_back(mk_item(CMD_WRITE, 0));
		cmd_q.push_back(mk_item(CMD_READ, 3));
		cmd_q.push_back(mk_item(CMD_WRITE, 0));
		cmd_q.push_back(mk_item(CMD_READ, 10));

		// Zero registers act as one channel and one slot; zero gain mutes
		wait_ring_idle();
		set_regs('0, '0, '0);
		cmd_q.push_back(mk_item(CMD_RESTART, 0));
		cmd_q.push_back(mk_item(CMD_WRITE, 0));
		cmd_q.push_back(mk_item(CMD_WRITE, 0));
		cmd_q.push_back(mk_item(CMD_READ, 2));

		// Random phases, each starting from an empty, running ring
		for (p = 0; p < N_PHASES; p++) begin
			wait_ring_idle();
			set_regs(CH_W'(ph_ch[p]), CAP_W'(ph_cap[p]), GAIN_W'(ph_gain[p]));
			src_idle_pct = ph_idle[p];
			snk_idle_pct = ph_idle[p];
			cmd_q.push_back(mk_item(CMD_RESTART, 0));
			repeat (PHASE_ITEMS) cmd_q.push_back(rand_item());
		end

		wait_ring_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
